@@ hdl/pbe_pkg.sv @@
// shared types and constants for the packbits encoder
package pbe_pkg;

   // default largest literal block and run length
   localparam int MAX_BLOCK_DEF = 128;

   // end of stream marker and run header base
   localparam logic [7:0] END_MARK = 8'd128;
   localparam logic [8:0] RUN_BASE = 9'd257;

   // coding mode held between words
   typedef enum logic [1:0] {
      MODE_LIT  = 2'd0,
      MODE_FULL = 2'd1,
      MODE_RUN  = 2'd2
   } mode_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LIT_HDR,
      ST_LIT_BODY,
      ST_RUN_HDR,
      ST_RUN_BYTE,
      ST_END,
      ST_WR0,
      ST_WR1
   } state_type;

   // source of the coded byte appended this cycle
   typedef enum logic [2:0] {
      SRC_NONE,
      SRC_LIT_HDR,
      SRC_LIT_BODY,
      SRC_RUN_HDR,
      SRC_RUN_BYTE,
      SRC_END
   } src_type;

   // deferred store write after a flush
   typedef enum logic [1:0] {
      WR_NONE,
      WR_ZERO,
      WR_ONE
   } wr_type;

   // work planned for the word just taken
   typedef struct packed {
      logic lit;
      logic run;
      logic endm;
      logic wr0;
      logic wr1;
   } plan_type;

   // datapath to controller
   typedef struct packed {
      plan_type plan;
      logic     slot_free;
      logic     body_done;
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      src_type src;
      logic    last;
      wr_type  wr;
   } cmd_type;

endpackage

@@ hdl/pbe_ctrl.sv @@
// sequencing state machine of the packbits encoder
module pbe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pbe_pkg::status_type status,
   output pbe_pkg::cmd_type    cmd
);
   import pbe_pkg::*;

   state_type state_ff;
   state_type state_in;
   state_type tail_state;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // where to go once the block or run bytes are out
   always_comb begin
      if (status.plan.endm) begin
         tail_state = ST_END;
      end else if (status.plan.wr0) begin
         tail_state = ST_WR0;
      end else begin
         tail_state = ST_IDLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (status.plan.lit) begin
               state_in = ST_LIT_HDR;
            end else if (status.plan.run) begin
               state_in = ST_RUN_HDR;
            end else if (status.plan.endm) begin
               state_in = ST_END;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LIT_HDR: begin
            if (status.slot_free) begin
               state_in = ST_LIT_BODY;
            end
         end
         ST_LIT_BODY: begin
            if (status.slot_free && status.body_done) begin
               state_in = tail_state;
            end
         end
         ST_RUN_HDR: begin
            if (status.slot_free) begin
               state_in = ST_RUN_BYTE;
            end
         end
         ST_RUN_BYTE: begin
            if (status.slot_free) begin
               state_in = tail_state;
            end
         end
         ST_END: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WR0: begin
            state_in = status.plan.wr1 ? ST_WR1 : ST_IDLE;
         end
         ST_WR1: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.src   = SRC_NONE;
      cmd.last  = 1'b0;
      cmd.wr    = WR_NONE;
      unique case (state_ff)
         ST_LIT_HDR: begin
            cmd.src = SRC_LIT_HDR;
         end
         ST_LIT_BODY: begin
            cmd.src  = SRC_LIT_BODY;
            cmd.last = status.body_done && !status.plan.endm;
         end
         ST_RUN_HDR: begin
            cmd.src = SRC_RUN_HDR;
         end
         ST_RUN_BYTE: begin
            cmd.src  = SRC_RUN_BYTE;
            cmd.last = !status.plan.endm;
         end
         ST_END: begin
            cmd.src  = SRC_END;
            cmd.last = 1'b1;
         end
         ST_WR0: begin
            cmd.wr = WR_ZERO;
         end
         ST_WR1: begin
            cmd.wr = WR_ONE;
         end
         default: begin
            cmd.src = SRC_NONE;
         end
      endcase
   end

endmodule

@@ hdl/pbe_datapath.sv @@
// byte store, coding decisions and output packing of the packbits encoder
module pbe_datapath #(
   parameter int MAX_BLOCK = pbe_pkg::MAX_BLOCK_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_kind,
   input  logic [7:0]         req_data_byte,
   input  pbe_pkg::cmd_type    cmd,
   output pbe_pkg::status_type status,
   output logic [63:0]        out_bytes,
   output logic [3:0]         byte_count,
   output logic               last_of_run,
   output logic               rsp_valid,
   input  logic               rsp_ready
);
   import pbe_pkg::*;

   localparam int AW = $clog2(MAX_BLOCK);
   localparam int FW = $clog2(MAX_BLOCK + 1);
   localparam logic [FW-1:0] FillMax = FW'(MAX_BLOCK);
   localparam logic [AW-1:0] TopM1 = AW'(MAX_BLOCK - 1);
   localparam logic [AW-1:0] TopM2 = AW'(MAX_BLOCK - 2);
   localparam logic [AW-1:0] TopM3 = AW'(MAX_BLOCK - 3);
   localparam logic [7:0] RunHdrMax = 8'(257 - MAX_BLOCK);

   // coding state
   mode_type        mode_ff, mode_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [7:0]      last_ff, last_in;
   logic [7:0]      prev_ff, prev_in;

   // planned flush
   plan_type        plan_ff, plan_in;
   logic [AW-1:0]   lit_top_ff, lit_top_in;
   logic [7:0]      run_hdr_ff, run_hdr_in;
   logic [7:0]      run_byte_ff, run_byte_in;
   logic [7:0]      wr_byte_ff, wr_byte_in;

   // byte store
   logic [7:0]      mem [MAX_BLOCK];
   logic            mem_we;
   logic [AW-1:0]   mem_addr;
   logic [7:0]      mem_wdata;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [7:0]      rd_data_ff;

   // packing and output word
   logic [63:0]     bld_ff, bld_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [63:0]     rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]      rsp_count_ff, rsp_count_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [FW-1:0]   fill_inc;
   logic            same_last;
   logic            same_second;
   logic            slot_free;
   logic            append;
   logic            complete;
   logic [7:0]      byte_sel;
   logic [63:0]     word_cat;

   assign fill_inc    = fill_ff + FW'(1);
   assign same_last   = (fill_ff != '0) && (req_data_byte == last_ff);
   assign same_second = (fill_ff >= FW'(2)) && (req_data_byte == prev_ff);

   // decide the coding step for the word being taken
   always_comb begin
      mode_in     = mode_ff;
      fill_in     = fill_ff;
      last_in     = last_ff;
      prev_in     = prev_ff;
      plan_in     = plan_ff;
      lit_top_in  = lit_top_ff;
      run_hdr_in  = run_hdr_ff;
      run_byte_in = run_byte_ff;
      wr_byte_in  = wr_byte_ff;
      if (cmd.load) begin
         plan_in     = '0;
         wr_byte_in  = req_data_byte;
         run_byte_in = last_ff;
         if (req_kind) begin
            // end of stream: flush what is held, then the marker
            plan_in.endm = 1'b1;
            if (fill_ff != '0) begin
               if (mode_ff != MODE_RUN || fill_ff == FW'(1)) begin
                  plan_in.lit = 1'b1;
                  lit_top_in  = AW'(fill_ff - FW'(1));
               end else begin
                  plan_in.run = 1'b1;
                  run_hdr_in  = 8'(RUN_BASE - 9'(fill_ff));
               end
            end
            mode_in = MODE_LIT;
            fill_in = '0;
         end else begin
            unique case (mode_ff)
               MODE_FULL: begin
                  plan_in.lit = 1'b1;
                  plan_in.wr0 = 1'b1;
                  mode_in     = MODE_LIT;
                  last_in     = req_data_byte;
                  if (req_data_byte == last_ff) begin
                     lit_top_in  = TopM2;
                     plan_in.wr1 = 1'b1;
                     fill_in     = FW'(2);
                     prev_in     = req_data_byte;
                  end else begin
                     lit_top_in = TopM1;
                     fill_in    = FW'(1);
                  end
               end
               MODE_RUN: begin
                  if (req_data_byte == last_ff) begin
                     if (fill_inc >= FillMax) begin
                        plan_in.run = 1'b1;
                        run_hdr_in  = RunHdrMax;
                        fill_in     = '0;
                        mode_in     = MODE_LIT;
                     end else begin
                        fill_in = fill_inc;
                     end
                  end else begin
                     plan_in.run = 1'b1;
                     plan_in.wr0 = 1'b1;
                     run_hdr_in  = 8'(RUN_BASE - 9'(fill_ff));
                     fill_in     = FW'(1);
                     last_in     = req_data_byte;
                     mode_in     = MODE_LIT;
                  end
               end
               default: begin
                  mode_in = MODE_LIT;
                  if (fill_inc == FillMax) begin
                     if (same_last) begin
                        // full block ending in a pair: keep the pair
                        plan_in.lit = 1'b1;
                        plan_in.wr0 = 1'b1;
                        plan_in.wr1 = 1'b1;
                        lit_top_in  = TopM3;
                        fill_in     = FW'(2);
                        last_in     = req_data_byte;
                        prev_in     = req_data_byte;
                     end else begin
                        mode_in = MODE_FULL;
                        fill_in = fill_inc;
                        prev_in = last_ff;
                        last_in = req_data_byte;
                     end
                  end else if (same_last && same_second) begin
                     // three equal bytes open a run
                     if (fill_inc > FW'(3)) begin
                        plan_in.lit = 1'b1;
                        lit_top_in  = AW'(fill_ff - FW'(3));
                     end
                     fill_in = FW'(3);
                     mode_in = MODE_RUN;
                     last_in = req_data_byte;
                  end else begin
                     fill_in = fill_inc;
                     prev_in = last_ff;
                     last_in = req_data_byte;
                  end
               end
            endcase
         end
      end
   end

   // store write port: new literal byte, or the bytes kept after a flush
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = fill_ff[AW-1:0];
      mem_wdata = req_data_byte;
      if (cmd.load && !req_kind && mode_ff != MODE_FULL && mode_ff != MODE_RUN) begin
         mem_we = 1'b1;
      end else if (cmd.wr == WR_ZERO) begin
         mem_we    = 1'b1;
         mem_addr  = '0;
         mem_wdata = wr_byte_ff;
      end else if (cmd.wr == WR_ONE) begin
         mem_we    = 1'b1;
         mem_addr  = AW'(1);
         mem_wdata = wr_byte_ff;
      end
   end

   // read index walks the block body
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign append    = (cmd.src != SRC_NONE) && slot_free;

   always_comb begin
      idx_in = '0;
      if (cmd.src == SRC_LIT_BODY) begin
         if (!append) begin
            idx_in = idx_ff;
         end else if (idx_ff != lit_top_ff) begin
            idx_in = idx_ff + AW'(1);
         end
      end
   end

   // byte store memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_in];
   end

   // coded byte selection
   always_comb begin
      unique case (cmd.src)
         SRC_LIT_HDR:  byte_sel = 8'(lit_top_ff);
         SRC_LIT_BODY: byte_sel = rd_data_ff;
         SRC_RUN_HDR:  byte_sel = run_hdr_ff;
         SRC_RUN_BYTE: byte_sel = run_byte_ff;
         SRC_END:      byte_sel = END_MARK;
         default:      byte_sel = '0;
      endcase
   end

   // pack bytes into words, first byte lowest
   assign word_cat = bld_ff | (64'(byte_sel) << {cnt_ff, 3'b000});
   assign complete = cmd.last || (cnt_ff == 3'd7);

   always_comb begin
      bld_in       = bld_ff;
      cnt_in       = cnt_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (append) begin
         if (complete) begin
            rsp_bytes_in = word_cat;
            rsp_count_in = {1'b0, cnt_ff} + 4'd1;
            rsp_last_in  = cmd.last;
            rsp_valid_in = 1'b1;
            bld_in       = '0;
            cnt_in       = '0;
         end else begin
            bld_in = word_cat;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LIT;
         fill_ff      <= '0;
         plan_ff      <= '0;
         idx_ff       <= '0;
         bld_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         plan_ff      <= plan_in;
         idx_ff       <= idx_in;
         bld_ff       <= bld_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      prev_ff      <= prev_in;
      lit_top_ff   <= lit_top_in;
      run_hdr_ff   <= run_hdr_in;
      run_byte_ff  <= run_byte_in;
      wr_byte_ff   <= wr_byte_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.plan      = plan_ff;
   assign status.slot_free = slot_free;
   assign status.body_done = (idx_ff == lit_top_ff);

   assign out_bytes   = rsp_bytes_ff;
   assign byte_count  = rsp_count_ff;
   assign last_of_run = rsp_last_ff;
   assign rsp_valid   = rsp_valid_ff;

endmodule

@@ hdl/packbits_encoder.sv @@
// packbits encoder: one byte word in, packed coded words out
// A word that codes nothing passes through accept and dispatch before the next is taken.
// A flush emits one coded byte per cycle while the output slot is free (up to MAX_BLOCK + 2 bytes),
// then rewrites up to two kept bytes into the byte store, one at a time through its single port.
// A finished result word waits in the output register while the next word is accepted.
// Synchronous active-high reset: empty store, literal mode, no result pending.
module packbits_encoder #(
   parameter int MAX_BLOCK = pbe_pkg::MAX_BLOCK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte [7:0]
   input  logic        req_tuser,   // kind [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_bytes [63:0], byte_count [67:64], zero [71:68]
   output logic        rsp_tlast
);
   import pbe_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [63:0] out_bytes;
   logic [3:0]  byte_count;

   // sequencer
   pbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, coding and packing
   pbe_datapath #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_tuser),
      .req_data_byte (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .out_bytes     (out_bytes),
      .byte_count    (byte_count),
      .last_of_run   (rsp_tlast),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready)
   );

   assign rsp_tdata = {4'b0000, byte_count, out_bytes};

endmodule

@@ tb/sv/tb_packbits_encoder.sv @@
`timescale 1ns / 1ps
// testbench for the packbits encoder: directed and random byte streams checked by a built-in coder
module tb_packbits_encoder;
   import pbe_pkg::*;

   localparam int   BLOCK_LEN    = MAX_BLOCK_DEF;
   localparam int   MAX_WORDS    = 17;
   localparam int   IDLE_PCT     = 13;
   localparam int   HOLD_CYCLES  = 300;
   localparam int   DRAIN_CYCLES = 20;
   localparam int   STALL_LIMIT  = 2000;
   localparam int   RANDOM_ITEMS = 60;
   localparam int   FLUSH_LEN    = 20;
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // one packed result word as the coder expects it
   typedef struct packed {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        last;
   } coded_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte [7:0]
   logic        req_tuser = 1'b0;    // kind [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // out_bytes [63:0], byte_count [67:64], zero [71:68]
   logic        rsp_tlast;

   // coder state mirrored from the block
   mode_type       coder_mode;
   int             coder_fill;
   logic [7:0]     coder_store [BLOCK_LEN];
   logic [7:0]     coded_bytes [$];
   coded_word_type coded_q [$];

   int mismatches    = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   int stall_left    = 0;
   bit steady_phase  = 1'b0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   packbits_encoder #(
      .MAX_BLOCK (BLOCK_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // literal block: header n-1, then the held bytes
   function automatic void put_literal(int n);
      if (n == 0 || n > BLOCK_LEN) return;
      coded_bytes.push_back(8'(n - 1));
      for (int i = 0; i < n; i++) coded_bytes.push_back(coder_store[i]);
   endfunction

   // run: header 257-n, then the repeated byte
   function automatic void put_run(int n);
      logic [8:0] hdr;
      hdr = RUN_BASE - 9'(n);
      coded_bytes.push_back(hdr[7:0]);
      coded_bytes.push_back(coder_store[0]);
   endfunction

   function automatic void keep_pair(logic [7:0] b);
      coder_store[0] = b;
      coder_store[1] = b;
      coder_fill = 2;
   endfunction

   // collecting literals, a third equal byte turns them into a run
   function automatic void code_literal(logic [7:0] cur);
      bit         has_last;
      bit         has_second;
      bit         same_last;
      logic [7:0] last_b;
      logic [7:0] second_b;
      has_last   = coder_fill >= 1;
      has_second = coder_fill >= 2;
      last_b     = has_last ? coder_store[(coder_fill - 1) % BLOCK_LEN] : 8'h00;
      second_b   = has_second ? coder_store[(coder_fill - 2) % BLOCK_LEN] : 8'h00;
      same_last  = has_last && cur == last_b;
      if (coder_fill >= BLOCK_LEN) coder_fill = BLOCK_LEN - 1;
      coder_store[coder_fill % BLOCK_LEN] = cur;
      coder_fill++;
      if (coder_fill == BLOCK_LEN) begin
         // a full store with an equal pair at its tail keeps the pair
         if (same_last) begin
            put_literal(coder_fill - 2);
            keep_pair(cur);
         end else begin
            coder_mode = MODE_FULL;
         end
      end else if (same_last && has_second && cur == second_b) begin
         if (coder_fill > 3) put_literal(coder_fill - 3);
         coder_store[0] = cur;
         coder_fill = 3;
         coder_mode = MODE_RUN;
      end
   endfunction

   // full store waiting one byte to decide the split
   function automatic void code_full(logic [7:0] cur);
      if (cur == coder_store[(coder_fill - 1) % BLOCK_LEN]) begin
         put_literal(coder_fill - 1);
         keep_pair(cur);
      end else begin
         put_literal(coder_fill);
         coder_store[0] = cur;
         coder_fill = 1;
      end
      coder_mode = MODE_LIT;
   endfunction

   // counting a run until it breaks or reaches the block length
   function automatic void code_run(logic [7:0] cur);
      if (cur == coder_store[0]) begin
         if (coder_fill < BLOCK_LEN) coder_store[coder_fill] = cur;
         coder_fill++;
         if (coder_fill >= BLOCK_LEN) begin
            put_run(BLOCK_LEN);
            coder_fill = 0;
            coder_mode = MODE_LIT;
         end
      end else begin
         put_run(coder_fill);
         coder_store[0] = cur;
         coder_fill = 1;
         coder_mode = MODE_LIT;
      end
   endfunction

   // end of stream: flush what is held, then the marker
   function automatic void code_end();
      if (coder_fill > 0) begin
         if (coder_mode != MODE_RUN || coder_fill == 1) put_literal(coder_fill);
         else put_run(coder_fill);
      end
      coded_bytes.push_back(END_MARK);
      coder_mode = MODE_LIT;
      coder_fill = 0;
   endfunction

   // code one accepted word and queue the packed words it yields
   function automatic void code_word(logic kind, logic [7:0] cur);
      int             n;
      int             cnt;
      coded_word_type w;
      coded_bytes.delete();
      if (kind == KIND_END) begin
         code_end();
      end else begin
         case (coder_mode)
            MODE_FULL: code_full(cur);
            MODE_RUN:  code_run(cur);
            default: begin
               coder_mode = MODE_LIT;
               code_literal(cur);
            end
         endcase
      end
      n = (coded_bytes.size() + 7) / 8;
      if (n > MAX_WORDS) n = MAX_WORDS;
      for (int k = 0; k < n; k++) begin
         w = '0;
         cnt = coded_bytes.size() - 8 * k;
         if (cnt > 8) cnt = 8;
         for (int i = 0; i < cnt; i++) w.bytes[8 * i +: 8] = coded_bytes[8 * k + i];
         w.count = 4'(cnt);
         w.last = (k + 1 == n);
         coded_q.push_back(w);
      end
   endfunction

   // compare one taken word with the oldest expectation
   task automatic check_coded_word(input logic [71:0] data, input logic last);
      coded_word_type want;
      if (coded_q.size() == 0) begin
         $display("%0t: unexpected word: expected none, actual data %h last %b",
                  $time, data, last);
         mismatches++;
      end else begin
         want = coded_q.pop_front();
         if (data[63:0] !== want.bytes) begin
            $display("%0t: out_bytes mismatch: expected %h, actual %h",
                     $time, want.bytes, data[63:0]);
            mismatches++;
         end
         if (data[67:64] !== want.count) begin
            $display("%0t: byte_count mismatch: expected %0d, actual %0d",
                     $time, want.count, data[67:64]);
            mismatches++;
         end
         if (data[71:68] !== 4'd0) begin
            $display("%0t: pad bits mismatch: expected 0, actual %h", $time, data[71:68]);
            mismatches++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
            mismatches++;
         end
      end
   endtask

   // result side: random stalls, long hold-offs on request, checking
   always @(posedge clock) begin
      if (hold_requests != holds_done) begin
         holds_done = hold_requests;
         stall_left = HOLD_CYCLES;
      end
      if (!reset && rsp_tvalid && rsp_tready) check_coded_word(rsp_tdata, rsp_tlast);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (steady_phase) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // offer one word, with an occasional gap before it
   task automatic send_word(input logic kind, input logic [7:0] value);
      int gap;
      if (!steady_phase && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(4, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      code_word(kind, value);
   endtask

   task automatic send_data(input logic [7:0] value);
      send_word(KIND_DATA, value);
   endtask

   // the byte rides along with an end word but is ignored
   task automatic send_end();
      send_word(KIND_END, 8'($urandom));
   endtask

   task automatic send_run(input logic [7:0] value, input int len);
      repeat (len) send_data(value);
   endtask

   // distinct bytes in a row, so no pair or run forms
   function automatic logic [7:0] spread_byte(logic [7:0] base, int i);
      return 8'(base + i * 37);
   endfunction

   task automatic send_spread(input int len, input logic [7:0] base);
      for (int i = 0; i < len; i++) send_data(spread_byte(base, i));
   endtask

   // half the time one of a few values that repeat, else any byte
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h5A;
         3: return 8'hA5;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_edge_bytes();
      // end with nothing held, with a single byte held, then with four alternating bytes held
      send_end();
      send_data(8'h00);
      send_end();
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'h00);
      send_data(8'hFF);
      send_end();
   endtask

   task automatic test_short_runs();
      // run closed by a new byte, which starts a literal block
      send_run(8'h55, 3);
      send_data(8'h56);
      send_end();
      // literals flushed ahead of a run, run still held at the end
      send_data(8'h01);
      send_data(8'h02);
      send_run(8'h07, 3);
      send_end();
      // pairs stay literal
      send_data(8'h10);
      send_data(8'h10);
      send_data(8'h11);
      send_data(8'h11);
      send_end();
   endtask

   task automatic test_backpressure();
      // receiver holds off while a multi-word flush piles up behind the output word
      send_spread(FLUSH_LEN, 8'h11);
      hold_requests++;
      send_end();
      send_run(8'hA5, 5);
      send_data(8'h5A);
      send_end();
   endtask

   task automatic test_random_stream();
      int sent;
      int r;
      int len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady_phase = (sent >= 15 && sent < 40);
         r = $urandom_range(99);
         if (r < 6) begin
            send_end();
            sent++;
         end else if (r < 60) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 5) : $urandom_range(4, 1);
            send_run(pick_byte(), len);
            sent += len;
         end else begin
            // noise
            len = $urandom_range(8, 1);
            repeat (len) send_data(pick_byte());
            sent += len;
         end
      end
      steady_phase = 1'b0;
      send_end();
   endtask

   // stall watchdog
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("packbits_encoder verification failed");
      $finish;
   end

   // test sequence
   initial begin
      coder_mode = MODE_LIT;
      coder_fill = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_edge_bytes();
      test_short_runs();
      test_backpressure();
      test_random_stream();
      req_tvalid <= 1'b0;
      while (coded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("packbits_encoder verification clean");
      end else begin
         $display("packbits_encoder verification failed");
      end
      $finish;
   end

endmodule
